[rtl/core/node_lock_handoff_arbiter_unit_macros.svh]
// Assertion macros for the node lock hand-off arbiter.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef NODE_LOCK_HANDOFF_ARBITER_UNIT_MACROS_SVH
`define NODE_LOCK_HANDOFF_ARBITER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/nlha_pkg.sv]
// Shared types and constants for the node lock hand-off arbiter.
// No dependencies; used by nlha_pick and the top level.
package nlha_pkg;

    localparam int REQUESTERS = 32;
    localparam int NODES      = 128;
    localparam int STAMP_W    = 48;
    localparam int WEIGHT_W   = 16;

    // Field widths of the word on each channel.
    localparam int REQ_W  = 5;
    localparam int NODE_W = 7;
    localparam int KEY_W  = (STAMP_W > WEIGHT_W) ? STAMP_W : WEIGHT_W;

    typedef enum logic [1:0] {
        OUT_GRANTED = 2'd0,
        OUT_QUEUED  = 2'd1,
        OUT_HANDED  = 2'd2,
        OUT_FREED   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACQ,
        ST_SCAN,
        ST_REL_FIN
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [STAMP_W-1:0]  stamp;
        logic [WEIGHT_W-1:0] weight;
    } wait_entry_t;

    localparam int ENTRY_W = $bits(wait_entry_t);

    // One scanned table entry, presented to the picker.
    typedef struct packed {
        logic             valid;
        logic             match;
        logic [REQ_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } cand_t;

    // Running result of the picker.
    typedef struct packed {
        logic             found;
        logic [REQ_W-1:0] idx;
    } pick_status_t;

endpackage

[rtl/core/nlha_wait_ram.sv]
// Single-port-write, single-port-read RAM with registered read data.
// Holds the waiting table; no package dependencies.
module nlha_wait_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/nlha_pick.sv]
// Running minimum over the scanned waiting entries for one release.
// Depends on nlha_pkg for the candidate and status structs.
module nlha_pick (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  nlha_pkg::cand_t       cand,
    output nlha_pkg::pick_status_t status
);

    logic                       found_reg, found_next;
    logic [nlha_pkg::REQ_W-1:0] idx_reg, idx_next;
    logic [nlha_pkg::KEY_W-1:0] best_reg, best_next;
    logic                       take;

    // Strict less-than keeps the lowest index on a tie, since the scan runs upward.
    assign take = cand.valid && cand.match && (!found_reg || (cand.key < best_reg));

    always_comb begin
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        if (clear) begin
            found_next = 1'b0;
            idx_next   = '0;
        end else if (take) begin
            found_next = 1'b1;
            idx_next   = cand.idx;
            best_next  = cand.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
        best_reg <= best_next;
    end

    assign status.found = found_reg;
    assign status.idx   = idx_reg;

endmodule

[rtl/core/node_lock_handoff_arbiter_unit.sv]
// Lock hand-off arbiter top level: control FSM, occupancy and waiting flags.
// Depends on nlha_pkg, nlha_wait_ram, nlha_pick and the assertion macro header.
//
// Usage: each word on the s_ channel is an acquire or a release of a node by a
// requester; each one yields exactly one word on the m_ channel (outcome and,
// for a hand-off, the requester that now holds the node).
// An acquire goes from acceptance through the acquire state to the result
// register. A release walks the waiting-table RAM one entry per cycle: one
// read per requester, then the read-data register, the picker register and
// the commit. A release of a node out of range skips the walk. Only one word
// is in flight; s_ready is high while the block is idle, so a new word can
// be taken in the cycle after the commit.
// The result sits in an output register; a new word is accepted while it waits,
// but the commit of that next word holds until m_ready frees the register.
// Reset (aresetn low, synchronous) frees all nodes, clears all waiting flags
// and sets the policy to first come first served. The waiting-table RAM is
// not cleared; its entries only count where the waiting flag is set.
// cfg_wr_data selects the policy (0 earliest stamp, 1 smallest weight); the user
// must write it only while the block is idle. The block itself does not enforce this.
`include "node_lock_handoff_arbiter_unit_macros.svh"

module node_lock_handoff_arbiter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [nlha_pkg::REQ_W-1:0]    s_requester,
    input  logic [nlha_pkg::NODE_W-1:0]   s_node_index,
    input  logic [nlha_pkg::STAMP_W-1:0]  s_arrival_stamp,
    input  logic [nlha_pkg::WEIGHT_W-1:0] s_job_weight,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_outcome,
    output logic [nlha_pkg::REQ_W-1:0]    m_handed_to
);

    nlha_pkg::state_t state_reg, state_next;

    logic                          policy_mode_reg;
    logic [nlha_pkg::NODES-1:0]    node_busy_reg;
    logic [nlha_pkg::REQUESTERS-1:0] is_waiting_reg;

    // Captured word.
    logic                          req_type_reg;
    logic [nlha_pkg::REQ_W-1:0]    requester_reg;
    logic [nlha_pkg::NODE_W-1:0]   node_reg;
    logic [nlha_pkg::STAMP_W-1:0]  stamp_reg;
    logic [nlha_pkg::WEIGHT_W-1:0] weight_reg;
    logic                          busy_hit_reg;

    logic [nlha_pkg::REQ_W:0]      scan_cnt_reg, scan_cnt_next;
    logic                          rd_valid_reg;
    logic [nlha_pkg::REQ_W-1:0]    rd_idx_reg;

    logic                          m_valid_reg;
    nlha_pkg::outcome_t            m_outcome_reg;
    logic [nlha_pkg::REQ_W-1:0]    m_handed_to_reg;

    logic                          in_accept;
    logic                          out_free;
    logic                          node_ok;
    logic                          req_ok;
    logic                          scan_issue;
    logic                          pick_clear;
    logic                          ram_we;
    logic                          out_load;
    nlha_pkg::outcome_t            out_outcome;
    logic [nlha_pkg::REQ_W-1:0]    out_handed;
    logic                          busy_wr;
    logic                          busy_val;
    logic                          wait_wr;
    logic                          wait_val;
    logic [nlha_pkg::REQ_W-1:0]    wait_idx;

    nlha_pkg::wait_entry_t         ram_wdata;
    nlha_pkg::wait_entry_t         ram_rdata;
    nlha_pkg::cand_t               cand;
    nlha_pkg::pick_status_t        pick;

    assign s_ready    = (state_reg == nlha_pkg::ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign node_ok    = (int'(node_reg) < nlha_pkg::NODES);
    assign req_ok     = (int'(requester_reg) < nlha_pkg::REQUESTERS);
    assign scan_issue = (state_reg == nlha_pkg::ST_SCAN) &&
                        (int'(scan_cnt_reg) < nlha_pkg::REQUESTERS);

    assign ram_wdata.node   = node_reg;
    assign ram_wdata.stamp  = stamp_reg;
    assign ram_wdata.weight = weight_reg;

    nlha_wait_ram #(
        .DEPTH (nlha_pkg::REQUESTERS),
        .WIDTH (nlha_pkg::ENTRY_W)
    ) u_wait_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (requester_reg),
        .wdata (ram_wdata),
        .re    (scan_issue),
        .raddr (scan_cnt_reg[nlha_pkg::REQ_W-1:0]),
        .rdata (ram_rdata)
    );

    // The entry read last cycle meets its waiting flag and the policy key here.
    assign cand.valid = rd_valid_reg;
    assign cand.match = is_waiting_reg[rd_idx_reg] && (ram_rdata.node == node_reg);
    assign cand.idx   = rd_idx_reg;
    assign cand.key   = policy_mode_reg ? nlha_pkg::KEY_W'(ram_rdata.weight)
                                        : nlha_pkg::KEY_W'(ram_rdata.stamp);

    nlha_pick u_pick (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (pick_clear),
        .cand    (cand),
        .status  (pick)
    );

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        pick_clear    = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        out_outcome   = nlha_pkg::OUT_QUEUED;
        out_handed    = '0;
        busy_wr       = 1'b0;
        busy_val      = 1'b0;
        wait_wr       = 1'b0;
        wait_val      = 1'b0;
        wait_idx      = requester_reg;
        unique case (state_reg)
            nlha_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (!s_req_type) begin
                        state_next = nlha_pkg::ST_ACQ;
                    end else if (int'(s_node_index) < nlha_pkg::NODES) begin
                        state_next    = nlha_pkg::ST_SCAN;
                        scan_cnt_next = '0;
                        pick_clear    = 1'b1;
                    end else begin
                        state_next = nlha_pkg::ST_REL_FIN;
                    end
                end
            end
            nlha_pkg::ST_ACQ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = nlha_pkg::ST_IDLE;
                    if (!node_ok) begin
                        out_outcome = nlha_pkg::OUT_QUEUED;
                    end else if (!busy_hit_reg) begin
                        out_outcome = nlha_pkg::OUT_GRANTED;
                        busy_wr     = 1'b1;
                        busy_val    = 1'b1;
                        wait_wr     = req_ok;
                    end else begin
                        out_outcome = nlha_pkg::OUT_QUEUED;
                        wait_wr     = req_ok;
                        wait_val    = 1'b1;
                        ram_we      = req_ok;
                    end
                end
            end
            nlha_pkg::ST_SCAN: begin
                if (scan_issue) begin
                    scan_cnt_next = scan_cnt_reg + {{nlha_pkg::REQ_W{1'b0}}, 1'b1};
                end else if (!rd_valid_reg) begin
                    state_next = nlha_pkg::ST_REL_FIN;
                end
            end
            nlha_pkg::ST_REL_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = nlha_pkg::ST_IDLE;
                    if (!node_ok) begin
                        out_outcome = nlha_pkg::OUT_FREED;
                    end else if (pick.found) begin
                        out_outcome = nlha_pkg::OUT_HANDED;
                        out_handed  = pick.idx;
                        busy_wr     = 1'b1;
                        busy_val    = 1'b1;
                        wait_wr     = 1'b1;
                        wait_idx    = pick.idx;
                    end else begin
                        out_outcome = nlha_pkg::OUT_FREED;
                        busy_wr     = 1'b1;
                    end
                end
            end
            default: begin
                state_next = nlha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= nlha_pkg::ST_IDLE;
            policy_mode_reg <= 1'b0;
            node_busy_reg   <= '0;
            is_waiting_reg  <= '0;
            scan_cnt_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_valid_reg <= scan_issue;
            if (cfg_wr_en) begin
                policy_mode_reg <= cfg_wr_data;
            end
            if (busy_wr) begin
                node_busy_reg[node_reg] <= busy_val;
            end
            if (wait_wr) begin
                is_waiting_reg[wait_idx] <= wait_val;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_type_reg  <= s_req_type;
            requester_reg <= s_requester;
            node_reg      <= s_node_index;
            stamp_reg     <= s_arrival_stamp;
            weight_reg    <= s_job_weight;
            // The occupancy map only changes at a commit, which never shares an
            // edge with an acceptance, so this bit stays current for the word.
            busy_hit_reg  <= node_busy_reg[s_node_index];
        end
        rd_idx_reg <= scan_cnt_reg[nlha_pkg::REQ_W-1:0];
        if (out_load) begin
            m_outcome_reg   <= out_outcome;
            m_handed_to_reg <= out_handed;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_outcome   = m_outcome_reg;
    assign m_handed_to = m_handed_to_reg;

    // The table is never written while the walk reads it.
    `NLHA_ASSERT_NOW(a_no_write_during_scan, state_reg == nlha_pkg::ST_SCAN, !ram_we, "waiting table written during release scan")
    // A new result never overwrites one the receiver has not taken.
    `NLHA_ASSERT_NOW(a_no_result_overwrite, out_load, !m_valid_reg || m_ready, "result register overwritten")
    // After a hand-off the node is held and the chosen waiter no longer waits.
    `NLHA_ASSERT_NEXT(a_handoff_commit, out_load && (out_outcome == nlha_pkg::OUT_HANDED), node_busy_reg[node_reg] && !is_waiting_reg[m_handed_to_reg], "hand-off not committed")
    // The acquire path is only entered for an acquire word, and only left by way of the result register.
    `NLHA_ASSERT_NEXT(a_acq_kind, state_reg == nlha_pkg::ST_ACQ, !req_type_reg, "acquire path entered for a release word")

endmodule
